// ===== rtl/core/assert_macros.svh =====
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_CLK_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define AST_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define AST_CLK_RST(label, clk, rst_n, prop)
`define AST_CLK(label, clk, prop)
`endif

`endif

// ===== rtl/core/rvs_pkg.sv =====
package rvs_pkg;

  localparam int ELEMS_PER_BONE = 12;
  localparam int ELEM_W         = 32;
  localparam int BONE_W         = 6;
  localparam int EL_W           = 4;
  localparam int COORD_W        = 32;
  localparam int AXES           = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [ELEMS_PER_BONE-1:0] mat_row_t;

  typedef struct packed {
    logic                      cmd;
    logic [BONE_W-1:0]         bone_index;
    logic [EL_W-1:0]           element_index;
    logic signed [ELEM_W-1:0]  element_value;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_last;
  } out_item_t;

  // one element write into a matrix row
  typedef struct packed {
    logic            en;
    logic [EL_W-1:0] el;
    elem_t           data;
  } wr_req_t;

  // load enables of the datapath stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

endpackage

// ===== rtl/core/rvs_store.sv =====
module rvs_store #(
  parameter int MAX_BONES = 64,
  parameter int ROW_AW    = 6
) (
  input  logic               clk,
  input  rvs_pkg::wr_req_t   wr,
  input  logic [ROW_AW-1:0]  wr_row,
  input  logic               rd_en,
  input  logic [ROW_AW-1:0]  rd_row,
  output rvs_pkg::mat_row_t  rd_data
);
  import rvs_pkg::*;

  // one row per bone, written one element at a time, read a whole row at once
  mat_row_t mem [MAX_BONES];
  mat_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_row][wr.el] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rvs_datapath.sv =====
module rvs_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  rvs_pkg::stage_en_t  en,
  input  rvs_pkg::in_item_t   item,
  input  logic                bone_ok,
  input  rvs_pkg::mat_row_t   mat,
  output rvs_pkg::out_item_t  res
);
  import rvs_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SH_W + 2;
  localparam int NPROD  = AXES * AXES;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh0000_0000_8000_0000);

  // stage 1: position beside the matrix row being read
  logic signed [COORD_W-1:0] pos_r [AXES];
  logic                      last1_r;
  logic                      ok1_r;

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      pos_r[0] <= item.pos_x;
      pos_r[1] <= item.pos_y;
      pos_r[2] <= item.pos_z;
      last1_r  <= item.last_vertex;
      ok1_r    <= bone_ok;
    end
  end

  // stage 2: nine products, column c times position component c
  mat_row_t                  m;
  logic signed [PROD_W-1:0]  prod_nxt [NPROD];
  logic signed [PROD_W-1:0]  prod_r   [NPROD];
  logic signed [ELEM_W-1:0]  tr_r     [AXES];
  logic                      last2_r;

  always_comb begin
    m = ok1_r ? mat : '0;
    for (int c = 0; c < AXES; c++) begin
      for (int r = 0; r < AXES; r++) begin
        prod_nxt[c*AXES + r] = PROD_W'(m[c*AXES + r]) * PROD_W'(pos_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      for (int k = 0; k < NPROD; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      for (int r = 0; r < AXES; r++) begin
        tr_r[r] <= m[NPROD + r];
      end
      last2_r <= last1_r;
    end
  end

  // stage 3: floor shift and sum per row
  logic signed [SH_W-1:0]  sh       [NPROD];
  logic signed [SUM_W-1:0] sum_nxt  [AXES];
  logic signed [SUM_W-1:0] sum_r    [AXES];
  logic                    last3_r;

  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      sh[k] = SH_W'(prod_r[k] >>> FRAC_BITS);
    end
    for (int r = 0; r < AXES; r++) begin
      sum_nxt[r] = SUM_W'(sh[r]) + SUM_W'(sh[AXES + r]) + SUM_W'(sh[2*AXES + r])
                 + SUM_W'(tr_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      for (int r = 0; r < AXES; r++) begin
        sum_r[r] <= sum_nxt[r];
      end
      last3_r <= last2_r;
    end
  end

  // stage 4: saturate into the output register
  logic signed [COORD_W-1:0] sat [AXES];
  out_item_t                 res_nxt;
  out_item_t                 res_r;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      if (sum_r[r] > SAT_HI) begin
        sat[r] = SAT_HI[COORD_W-1:0];
      end else if (sum_r[r] < SAT_LO) begin
        sat[r] = SAT_LO[COORD_W-1:0];
      end else begin
        sat[r] = sum_r[r][COORD_W-1:0];
      end
    end
    res_nxt.out_x    = sat[0];
    res_nxt.out_y    = sat[1];
    res_nxt.out_z    = sat[2];
    res_nxt.out_last = last3_r;
  end

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/rigid_vertex_skinning.sv =====
// Rigid single-bone vertex skinning. Bone matrices (3x4, signed fixed point
// with FRAC_BITS fraction bits) live in an on-chip store of MAX_BONES rows of
// twelve 32-bit elements; a write transaction (cmd 0) sets one element, a
// transform transaction (cmd 1) reads the whole row of its bone and returns
// M*p + t with each product floored by FRAC_BITS and each component saturated
// to 32 bits. One transaction of either kind is taken every clock while
// in_ready is high, which out_ready low can hold off. A transform's result
// is registered in turn by the store read at the accepting edge, then the
// nine-multiplier stage, the adder stage and the saturating output stage.
// A write is visible to a transform accepted on the very next clock. Store
// contents are undefined until written, and a transform on a bone at or
// beyond MAX_BONES returns zero coordinates.
`include "assert_macros.svh"

module rigid_vertex_skinning #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rvs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rvs_pkg::out_item_t  out_data
);
  import rvs_pkg::*;

  localparam int ROW_AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int EXT_W  = ROW_AW + BONE_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic take2, take3, take4;
  logic accept;
  logic bone_ok;
  logic [EXT_W-1:0]  bone_ext;
  logic [ROW_AW-1:0] row;
  wr_req_t   wr;
  stage_en_t en;
  mat_row_t  mat;

  assign bone_ext = EXT_W'(in_data.bone_index);
  assign bone_ok  = bone_ext < EXT_W'(MAX_BONES);
  assign row      = bone_ext[ROW_AW-1:0];

  // stage hand-off, each stage moves on when the next is empty or moving
  always_comb begin
    take4  = v3_r && (!v4_r || out_ready);
    take3  = v2_r && (!v3_r || take4);
    take2  = v1_r && (!v2_r || take3);
    in_ready = !v1_r || take2;
    accept = in_valid && in_ready;

    v1_nxt = (accept && in_data.cmd == CMD_XFORM) || (v1_r && !take2);
    v2_nxt = take2 || (v2_r && !take3);
    v3_nxt = take3 || (v3_r && !take4);
    v4_nxt = take4 || (v4_r && !out_ready);

    en.ld1 = accept && in_data.cmd == CMD_XFORM;
    en.ld2 = take2;
    en.ld3 = take3;
    en.ld4 = take4;

    wr.en   = accept && in_data.cmd == CMD_WRITE && bone_ok
              && in_data.element_index < EL_W'(ELEMS_PER_BONE);
    wr.el   = in_data.element_index;
    wr.data = in_data.element_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  rvs_store #(
    .MAX_BONES (MAX_BONES),
    .ROW_AW    (ROW_AW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_row  (row),
    .rd_en   (en.ld1),
    .rd_row  (row),
    .rd_data (mat)
  );

  rvs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .en      (en),
    .item    (in_data),
    .bone_ok (bone_ok),
    .mat     (mat),
    .res     (out_data)
  );

  assign out_valid = v4_r;

  // a transform transaction always lands in the first stage
  `AST_CLK_RST(a_xform_enters, clk, rst_n, (accept && in_data.cmd == CMD_XFORM) |=> v1_r)
  // a result handed to the output stage is presented on the next clock
  `AST_CLK_RST(a_take_presents, clk, rst_n, take4 |=> out_valid)
  // a stalled adder stage keeps its transaction
  `AST_CLK_RST(a_stage3_holds, clk, rst_n, (v3_r && !take4) |=> v3_r)

endmodule
